// ===== design/assert_macros.svh =====
// assertion macros used by the correlation matrix accumulator top file
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every edge outside reset
`define CMA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define CMA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CMA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cma_pkg.sv =====
// shared types and constants of the correlation matrix accumulator
// no dependencies
package cma_pkg;

	localparam int FEAT_MAX_DEF = 8;
	localparam int CNT_W  = 4;
	localparam int FIDX_W = 3;
	localparam int VAL_W  = 32;
	localparam int DEV_W  = 33;
	localparam int SUM_W  = 64;
	localparam int CORR_W = 16;
	localparam int ROOT_W = 32;
	localparam int K_W    = 5;
	localparam int Q_W    = 22;
	localparam int DIVI_W = 8;

	// item kinds
	localparam logic [1:0] KIND_MEAN   = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0]              kind;
		logic [FIDX_W-1:0]       element_index;
		logic signed [VAL_W-1:0] element_value;
		logic                    element_null;
	} item_t;

	typedef struct packed {
		logic [FIDX_W-1:0]        row;
		logic [FIDX_W-1:0]        column;
		logic signed [CORR_W-1:0] correlation;
		logic                     zero_variance;
		logic                     status;
		logic                     last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXEC, ST_ACC_RD, ST_ACC_MUL, ST_ACC_WR, ST_ERR,
		ST_DG_RD, ST_DG_LD, ST_DG_NORM, ST_DG_SQRT, ST_DG_WR,
		ST_PR_RD, ST_PR_LD, ST_PR_DIV, ST_PR_OUT, ST_CLEAR
	} state_t;

	typedef struct packed {
		logic item_ld;
		logic mean_wr;
		logic dev_wr;
		logic cnt_clr;
		logic step_pair;
		logic step_diag;
		logic acc_mul;
		logic acc_wr;
		logic diag_sel;
		logic dg_ld;
		logic norm_step;
		logic sq_init;
		logic sq_step;
		logic root_wr;
		logic pr_rd;
		logic pr_ld;
		logic div_step;
		logic emit_pair;
		logic emit_err;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic is_mean;
		logic is_sample;
		logic is_finish;
		logic in_range;
		logic completes;
		logic vec_ok;
		logic mean_ok;
		logic pair_last;
		logic diag_last;
		logic x_zero;
		logic norm_done;
		logic sq_last;
		logic special;
		logic div_fin;
	} sts_t;

endpackage

// ===== design/cma_ram.sv =====
// generic single write port memory with registered read
// no dependencies
module cma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/cma_ctrl.sv =====
// controller state machine of the correlation matrix accumulator
// depends on cma_pkg
module cma_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cma_pkg::sts_t sts,
	output cma_pkg::cmd_t cmd,
	output logic          busy
);
	import cma_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_EXEC;
			ST_EXEC: begin
				state_d = ST_IDLE;
				if (sts.is_sample && sts.in_range && sts.completes && sts.vec_ok)
					state_d = ST_ACC_RD;
				else if (sts.is_finish)
					state_d = sts.mean_ok ? ST_DG_RD : ST_ERR;
			end
			ST_ACC_RD:  state_d = ST_ACC_MUL;
			ST_ACC_MUL: state_d = ST_ACC_WR;
			ST_ACC_WR:  state_d = sts.pair_last ? ST_IDLE : ST_ACC_RD;
			ST_ERR:     state_d = ST_CLEAR;
			ST_DG_RD:   state_d = ST_DG_LD;
			ST_DG_LD:   state_d = ST_DG_NORM;
			ST_DG_NORM: begin
				if (sts.x_zero) state_d = ST_DG_WR;
				else if (sts.norm_done) state_d = ST_DG_SQRT;
			end
			ST_DG_SQRT: if (sts.sq_last) state_d = ST_DG_WR;
			ST_DG_WR:   state_d = sts.diag_last ? ST_PR_RD : ST_DG_RD;
			ST_PR_RD:   state_d = ST_PR_LD;
			ST_PR_LD:   state_d = sts.special ? ST_PR_OUT : ST_PR_DIV;
			ST_PR_DIV:  if (sts.div_fin) state_d = ST_PR_OUT;
			ST_PR_OUT:  state_d = sts.pair_last ? ST_CLEAR : ST_PR_RD;
			ST_CLEAR:   state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: cmd.item_ld = start;
			ST_EXEC: begin
				cmd.mean_wr = sts.is_mean && sts.in_range;
				cmd.dev_wr  = sts.is_sample && sts.in_range;
				cmd.cnt_clr = 1'b1;
			end
			ST_ACC_RD:  ;
			ST_ACC_MUL: cmd.acc_mul = 1'b1;
			ST_ACC_WR: begin
				cmd.acc_wr    = 1'b1;
				cmd.step_pair = 1'b1;
			end
			ST_ERR: cmd.emit_err = 1'b1;
			ST_DG_RD: cmd.diag_sel = 1'b1;
			ST_DG_LD: begin
				cmd.diag_sel = 1'b1;
				cmd.dg_ld    = 1'b1;
			end
			ST_DG_NORM: begin
				cmd.sq_init   = !sts.x_zero && sts.norm_done;
				cmd.norm_step = !sts.x_zero && !sts.norm_done;
			end
			ST_DG_SQRT: cmd.sq_step = 1'b1;
			ST_DG_WR: begin
				cmd.root_wr   = 1'b1;
				cmd.step_diag = !sts.diag_last;
				cmd.cnt_clr   = sts.diag_last;
			end
			ST_PR_RD:  cmd.pr_rd = 1'b1;
			ST_PR_LD:  cmd.pr_ld = 1'b1;
			ST_PR_DIV: cmd.div_step = !sts.div_fin;
			ST_PR_OUT: begin
				cmd.emit_pair = 1'b1;
				cmd.step_pair = 1'b1;
			end
			ST_CLEAR: cmd.clear = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== design/cma_dpath.sv =====
// datapath of the correlation matrix accumulator: stores, multiplier,
// square root and divider units, result register; depends on cma_pkg, cma_ram
module cma_dpath #(
	parameter int MAX_FEATURES = cma_pkg::FEAT_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cma_pkg::CNT_W-1:0]  cfg_data,
	input  cma_pkg::item_t             item,
	input  cma_pkg::cmd_t              cmd,
	output cma_pkg::sts_t              sts,
	output logic                       result_valid,
	output cma_pkg::result_t           result
);
	import cma_pkg::*;

	localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int SA_W  = 2 * IDX_W;
	localparam int SUM_D = 1 << SA_W;
	localparam logic [SUM_W-1:0] S_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] S_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	logic [CNT_W-1:0] feat_q, nm1;
	item_t            item_q;
	logic [IDX_W-1:0] idx_s, r_q, c_q;
	logic [MAX_FEATURES-1:0] mask_q, full;
	logic             mnull_q, drop_q, drop_base, drop_new;
	logic signed [VAL_W-1:0] mean_q [MAX_FEATURES];
	logic [DEV_W-1:0] dev_wdata, dev_a, dev_b;

	// feature count register, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feat_q <= CNT_W'(MAX_FEATURES);
		end else if (cfg_we) begin
			if (cfg_data == '0) feat_q <= CNT_W'(1);
			else if (cfg_data > CNT_W'(MAX_FEATURES)) feat_q <= CNT_W'(MAX_FEATURES);
			else feat_q <= cfg_data;
		end
	end

	assign nm1   = feat_q - CNT_W'(1);
	assign idx_s = item_q.element_index[IDX_W-1:0];

	always_comb begin
		for (int i = 0; i < MAX_FEATURES; i++) begin
			full[i] = (CNT_W'(i) < feat_q);
		end
	end

	// item word latch
	always_ff @(posedge clk) begin
		if (cmd.item_ld) item_q <= item;
	end

	// sample drop flag as it stands after this word
	assign drop_base = (item_q.element_index == '0) ? 1'b0 : drop_q;
	assign drop_new  = drop_base | item_q.element_null;

	// mean store and its flags
	always_ff @(posedge clk) begin
		if (cmd.mean_wr) mean_q[idx_s] <= item_q.element_null ? '0 : item_q.element_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			mnull_q <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			if (cmd.mean_wr) begin
				if (item_q.element_index == '0) begin
					mask_q  <= MAX_FEATURES'(1);
					mnull_q <= item_q.element_null;
				end else begin
					mask_q[idx_s] <= 1'b1;
					mnull_q       <= mnull_q | item_q.element_null;
				end
			end
			if (cmd.dev_wr) drop_q <= sts.completes ? 1'b0 : drop_new;
			if (cmd.clear) drop_q <= 1'b0;
		end
	end

	// deviation from the mean, two copies for two read addresses
	assign dev_wdata = item_q.element_null ? '0 :
		({item_q.element_value[VAL_W-1], item_q.element_value} -
		 {mean_q[idx_s][VAL_W-1], mean_q[idx_s]});

	cma_ram #(.WIDTH(DEV_W), .DEPTH(MAX_FEATURES), .AW(IDX_W)) u_dev_a (
		.clk(clk), .we(cmd.dev_wr), .waddr(idx_s), .wdata(dev_wdata),
		.raddr(r_q), .rdata(dev_a)
	);
	cma_ram #(.WIDTH(DEV_W), .DEPTH(MAX_FEATURES), .AW(IDX_W)) u_dev_b (
		.clk(clk), .we(cmd.dev_wr), .waddr(idx_s), .wdata(dev_wdata),
		.raddr(c_q), .rdata(dev_b)
	);

	// pair counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
		end else if (cmd.cnt_clr) begin
			r_q <= '0;
			c_q <= '0;
		end else if (cmd.step_diag) begin
			r_q <= r_q + IDX_W'(1);
		end else if (cmd.step_pair) begin
			if (CNT_W'(c_q) == nm1) begin
				r_q <= r_q + IDX_W'(1);
				c_q <= r_q + IDX_W'(1);
			end else begin
				c_q <= c_q + IDX_W'(1);
			end
		end
	end

	// scatter sum memory with per-entry valid flags
	logic [SA_W-1:0]  s_raddr, s_waddr;
	logic [SUM_W-1:0] sum_rd, sum_in, sum_new;
	logic [SUM_D-1:0] vld_q;
	logic             rvld_q;

	assign s_raddr = cmd.diag_sel ? {r_q, r_q} : {r_q, c_q};
	assign s_waddr = {r_q, c_q};

	cma_ram #(.WIDTH(SUM_W), .DEPTH(SUM_D), .AW(SA_W)) u_sum (
		.clk(clk), .we(cmd.acc_wr), .waddr(s_waddr), .wdata(sum_new),
		.raddr(s_raddr), .rdata(sum_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[s_raddr];
			if (cmd.clear) vld_q <= '0;
			else if (cmd.acc_wr) vld_q[s_waddr] <= 1'b1;
		end
	end

	assign sum_in = rvld_q ? sum_rd : '0;

	// deviation product, then saturating accumulate
	logic [DEV_W-1:0]   mag_a, mag_b;
	logic [2*DEV_W-1:0] prod_q;
	logic               pneg_q;
	logic [SUM_W-1:0]   acc_q, psat;
	logic [SUM_W:0]     asum;

	assign mag_a = dev_a[DEV_W-1] ? (~dev_a + DEV_W'(1)) : dev_a;
	assign mag_b = dev_b[DEV_W-1] ? (~dev_b + DEV_W'(1)) : dev_b;

	always_ff @(posedge clk) begin
		if (cmd.acc_mul) begin
			prod_q <= mag_a * mag_b;
			pneg_q <= dev_a[DEV_W-1] ^ dev_b[DEV_W-1];
			acc_q  <= sum_in;
		end
	end

	always_comb begin
		if (pneg_q) begin
			if (prod_q >= (2*DEV_W)'(S_MIN)) psat = S_MIN;
			else psat = ~prod_q[SUM_W-1:0] + SUM_W'(1);
		end else begin
			if (prod_q > (2*DEV_W)'(S_MAX)) psat = S_MAX;
			else psat = prod_q[SUM_W-1:0];
		end
		asum = {acc_q[SUM_W-1], acc_q} + {psat[SUM_W-1], psat};
		if (asum[SUM_W] != asum[SUM_W-1]) sum_new = asum[SUM_W] ? S_MIN : S_MAX;
		else sum_new = asum[SUM_W-1:0];
	end

	// diagonal normalise and square root, two bits a cycle
	logic [SUM_W-1:0] x_q, res_q, bit_q, sq_t;
	logic [K_W-1:0]   k_q;
	logic             dz_q;
	logic [ROOT_W-1:0] root_q [MAX_FEATURES];
	logic [K_W-1:0]    rk_q   [MAX_FEATURES];
	logic              rz_q   [MAX_FEATURES];

	assign sq_t = res_q + bit_q;

	always_ff @(posedge clk) begin
		if (cmd.dg_ld) begin
			x_q  <= sum_in;
			k_q  <= '0;
			dz_q <= (sum_in == '0);
		end else if (cmd.norm_step) begin
			x_q <= x_q << 2;
			k_q <= k_q + K_W'(1);
		end else if (cmd.sq_init) begin
			res_q <= '0;
			bit_q <= SUM_W'(1) << (SUM_W - 2);
		end else if (cmd.sq_step) begin
			if (x_q >= sq_t) begin
				x_q   <= x_q - sq_t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.root_wr) begin
			root_q[r_q] <= res_q[ROOT_W-1:0];
			rk_q[r_q]   <= k_q;
			rz_q[r_q]   <= dz_q;
		end
	end

	// pair operands and restoring divider
	logic [ROOT_W-1:0] ra_q, rb_q;
	logic [K_W-1:0]    ka_q, kb_q;
	logic              za_q, zb_q, fin_q;
	logic [SUM_W-1:0]  s_q, d_q, m_q, rem_q, mag_s;
	logic [DIVI_W-1:0] i_q, tot_q;
	logic [Q_W-1:0]    q_q, q_n, qr;
	logic [SUM_W:0]    rem_sh;
	logic              ge;

	assign mag_s       = sum_in[SUM_W-1] ? (~sum_in + SUM_W'(1)) : sum_in;
	assign rem_sh      = {rem_q, m_q[SUM_W-1]};
	assign ge          = (rem_sh >= {1'b0, d_q});
	assign q_n         = {q_q[Q_W-2:0], ge};

	always_ff @(posedge clk) begin
		if (cmd.pr_rd) begin
			rb_q <= root_q[c_q];
			kb_q <= rk_q[c_q];
			zb_q <= rz_q[c_q];
			if (r_q == c_q) begin
				ra_q <= root_q[c_q];
				ka_q <= rk_q[c_q];
				za_q <= rz_q[c_q];
			end
		end
		if (cmd.pr_ld) begin
			s_q   <= sum_in;
			d_q   <= ra_q * rb_q;
			m_q   <= mag_s;
			rem_q <= '0;
			q_q   <= '0;
			i_q   <= '0;
			fin_q <= 1'b0;
			tot_q <= DIVI_W'(SUM_W + 16) + DIVI_W'(ka_q) + DIVI_W'(kb_q);
		end else if (cmd.div_step) begin
			m_q   <= m_q << 1;
			rem_q <= ge ? SUM_W'(rem_sh - {1'b0, d_q}) : rem_sh[SUM_W-1:0];
			i_q   <= i_q + DIVI_W'(1);
			if (q_n > (Q_W'(1) << 20)) begin
				q_q   <= (Q_W'(1) << 20) + Q_W'(1);
				fin_q <= 1'b1;
			end else begin
				q_q   <= q_n;
				fin_q <= (i_q + DIVI_W'(1) == tot_q);
			end
		end
	end

	// result word register
	logic signed [CORR_W-1:0] corr;
	assign qr = (q_q + Q_W'(1)) >> 1;

	always_comb begin
		if (r_q == c_q) corr = CORR_W'(32767);
		else if (za_q || zb_q) corr = '0;
		else if (s_q[SUM_W-1]) corr = (qr > Q_W'(32768)) ? CORR_W'(-32768) :
			CORR_W'(~qr + Q_W'(1));
		else corr = (qr > Q_W'(32767)) ? CORR_W'(32767) : CORR_W'(qr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit_pair | cmd.emit_err;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			result <= '{row: '0, column: '0, correlation: '0,
				zero_variance: 1'b0, status: 1'b1, last: 1'b1};
		end else if (cmd.emit_pair) begin
			result.row           <= FIDX_W'(r_q);
			result.column        <= FIDX_W'(c_q);
			result.correlation   <= corr;
			result.zero_variance <= za_q || zb_q;
			result.status        <= 1'b0;
			result.last          <= sts.pair_last;
		end
	end

	// decode and status
	always_comb begin
		sts           = '0;
		sts.is_mean   = (item_q.kind == KIND_MEAN);
		sts.is_sample = (item_q.kind == KIND_SAMPLE);
		sts.is_finish = (item_q.kind == KIND_FINISH);
		sts.in_range  = (CNT_W'(item_q.element_index) < feat_q);
		sts.completes = (CNT_W'(item_q.element_index) == nm1);
		sts.mean_ok   = ((mask_q & full) == full) && !mnull_q;
		sts.vec_ok    = !drop_new && sts.mean_ok;
		sts.pair_last = (CNT_W'(r_q) == nm1) && (CNT_W'(c_q) == nm1);
		sts.diag_last = (CNT_W'(r_q) == nm1);
		sts.x_zero    = dz_q;
		sts.norm_done = |x_q[SUM_W-1:SUM_W-2];
		sts.sq_last   = bit_q[0];
		sts.special   = (r_q == c_q) || za_q || zb_q;
		sts.div_fin   = fin_q;
	end

endmodule

// ===== design/correlation_matrix_accumulator.sv =====
// correlation matrix accumulator: a completing sample vector runs read, multiply and write for
// each of the n*(n+1)/2 pairs in the accumulate loop (one multiplier); finish gives one error
// word if a mean is missing or null, else per diagonal term normalise and bit-pair square root,
// then per pair read, load and one-bit-a-cycle division (skipped on diagonal and zero-variance
// pairs); results appear one a cycle at most, never stalled; next item taken once busy falls
// reset: feature count back to maximum, scatter sum cleared at once through valid flags
module correlation_matrix_accumulator #(
	parameter int MAX_FEATURES = cma_pkg::FEAT_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cma_pkg::CNT_W-1:0] cfg_data,
	input  logic                      start,
	input  cma_pkg::item_t            item,
	output logic                      busy,
	output logic                      result_valid,
	output cma_pkg::result_t          result
);
	import cma_pkg::*;
	`include "assert_macros.svh"

	cmd_t cmd;
	sts_t sts;

	// sequencer
	cma_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
	);

	// arithmetic and storage
	cma_dpath #(.MAX_FEATURES(MAX_FEATURES)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.item(item), .cmd(cmd), .sts(sts),
		.result_valid(result_valid), .result(result)
	);

	// checks
	`CMA_ASSERT_IMP(a_res_busy, result_valid, busy, "result word outside a finish run")
	`CMA_ASSERT_NXT(a_last_ends, result_valid && result.last, !result_valid, "word after last")
	`CMA_ASSERT_IMP(a_err_last, result_valid && result.status, result.last, "error not last")
	`CMA_ASSERT(a_upper, !result_valid || (result.column >= result.row), "column below row")

endmodule
